// ----- sv/sfd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register indexes and Q16.16 arithmetic helpers for the
// staggered-grid finite-difference update unit. Depends on nothing else.
package sfd_pkg;

  // Q16.16 limits.
  localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;

  // Number of register stages from input to output.
  localparam int unsigned NumStg = 6;

  // Register reset values.
  localparam logic signed [31:0] CoefSecondRst = 32'sd32768;
  localparam logic signed [31:0] CoefNearRst   = 32'sd36864;
  localparam logic signed [31:0] CoefFarRst    = -32'sd1365;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_USE_FOURTH = 3'd0,
    CFG_AXIS_IS_X  = 3'd1,
    CFG_COEF_SEC   = 3'd2,
    CFG_COEF_NEAR  = 3'd3,
    CFG_COEF_FAR   = 3'd4
  } cfg_idx_e;

  // Input beat.
  typedef struct packed {
    logic signed [31:0] acc_in;
    logic signed [31:0] mem_in;
    logic signed [31:0] media_factor;
    logic signed [31:0] mem_coef;
    logic signed [31:0] near_plus;
    logic signed [31:0] near_minus;
    logic signed [31:0] far_plus;
    logic signed [31:0] far_minus;
    logic               first_in_row;
    logic               last_in_row;
  } in_t;

  // Output beat.
  typedef struct packed {
    logic signed [31:0] acc_out;
    logic signed [31:0] mem_out;
    logic               row_done;
  } out_t;

  // Saturating add of two Q16.16 values.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      r = s[32] ? QMin : QMax;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // Saturating subtract of two Q16.16 values.
  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = 33'(a) - 33'(b);
    if (s[32] != s[31]) begin
      r = s[32] ? QMin : QMax;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // Q16.16 product: exact 64-bit product, floor shift by 16, saturate.
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] prod;
    logic        [47:0] sh;
    logic signed [31:0] r;
    prod = 64'(a) * 64'(b);
    sh   = prod[63:16];
    if (!sh[47] && (|sh[46:31])) begin
      r = QMax;
    end else if (sh[47] && !(&sh[46:31])) begin
      r = QMin;
    end else begin
      r = sh[31:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/staggered_fd_update_with_memory_unit.sv -----
`timescale 1ns / 1ps
// Top level of the staggered-grid finite-difference update unit.
// Depends on sfd_pkg for beat types, register indexes and arithmetic.
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+-----------------------------
//  in       | to unit   | in_valid_i / in_stall_o | in_data_i  (sfd_pkg::in_t)
//  out      | from unit | out_valid_o/ out_stall_i| out_data_o (sfd_pkg::out_t)
//  cfg      | to unit   | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// One grid point enters per cycle while the input is not stalled; each passes
// through the six register stages, three of which hold one multiplier level.
// Reset (rst_ni low) clears all stage valid bits and loads register defaults.
// Each stage holds its beat only while the stage after it is full and held,
// so idle slots are squeezed out and input is stalled only when all six stages
// are full and the output is stalled. Register writes are always accepted.
module staggered_fd_update_with_memory_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sfd_pkg::in_t       in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sfd_pkg::out_t      out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned Last = sfd_pkg::NumStg - 1;

  // Configuration registers.
  logic               fourth_q;
  logic               axis_x_q;
  logic signed [31:0] coef_sec_q;
  logic signed [31:0] coef_near_q;
  logic signed [31:0] coef_far_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fourth_q    <= 1'b1;
      axis_x_q    <= 1'b0;
      coef_sec_q  <= sfd_pkg::CoefSecondRst;
      coef_near_q <= sfd_pkg::CoefNearRst;
      coef_far_q  <= sfd_pkg::CoefFarRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (sfd_pkg::cfg_idx_e'(cfg_index_i))
        sfd_pkg::CFG_USE_FOURTH: fourth_q    <= cfg_data_i[0];
        sfd_pkg::CFG_AXIS_IS_X:  axis_x_q    <= cfg_data_i[0];
        sfd_pkg::CFG_COEF_SEC:   coef_sec_q  <= cfg_data_i;
        sfd_pkg::CFG_COEF_NEAR:  coef_near_q <= cfg_data_i;
        sfd_pkg::CFG_COEF_FAR:   coef_far_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Stage valid bits and load enables. A stage loads when it is empty or
  // the stage after it moves on.
  logic [Last:0] v_q, v_d, en;

  always_comb begin
    en[Last] = !v_q[Last] || !out_stall_i;
    for (int k = Last - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k <= Last; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[Last];

  // Stage 1: differences and stencil order.
  logic signed [31:0] s1_a_q, s1_cp_q, s1_x_q, s1_ks_q, s1_d1_q, s1_d2_q;
  logic               s1_fourth_q, s1_last_q;
  logic               row_end;

  assign row_end = axis_x_q && (in_data_i.first_in_row || in_data_i.last_in_row);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_a_q      <= in_data_i.acc_in;
      s1_cp_q     <= in_data_i.mem_in;
      s1_x_q      <= in_data_i.media_factor;
      s1_ks_q     <= in_data_i.mem_coef;
      s1_d1_q     <= sfd_pkg::sat_sub(in_data_i.near_plus, in_data_i.near_minus);
      s1_d2_q     <= sfd_pkg::sat_sub(in_data_i.far_plus, in_data_i.far_minus);
      s1_fourth_q <= fourth_q && !row_end;
      s1_last_q   <= in_data_i.last_in_row;
    end
  end

  // Stage 2: coefficient products for both orders in parallel.
  logic signed [31:0] s2_a_q, s2_cp_q, s2_x_q, s2_ks_q, s2_d1_q;
  logic signed [31:0] s2_p1_q, s2_p2_q, s2_m_q;
  logic               s2_fourth_q, s2_last_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_a_q      <= s1_a_q;
      s2_cp_q     <= s1_cp_q;
      s2_x_q      <= s1_x_q;
      s2_ks_q     <= s1_ks_q;
      s2_d1_q     <= s1_d1_q;
      s2_p1_q     <= sfd_pkg::qmul(coef_near_q, s1_d1_q);
      s2_p2_q     <= sfd_pkg::qmul(coef_far_q, s1_d2_q);
      s2_m_q      <= sfd_pkg::qmul(s1_x_q, coef_sec_q);
      s2_fourth_q <= s1_fourth_q;
      s2_last_q   <= s1_last_q;
    end
  end

  // Stage 3: sum the fourth-order terms and pick the operands of the
  // stencil product.
  logic signed [31:0] s3_a_q, s3_cp_q, s3_ks_q, s3_opa_q, s3_opb_q;
  logic               s3_last_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_a_q    <= s2_a_q;
      s3_cp_q   <= s2_cp_q;
      s3_ks_q   <= s2_ks_q;
      s3_opa_q  <= s2_fourth_q ? s2_x_q : s2_m_q;
      s3_opb_q  <= s2_fourth_q ? sfd_pkg::sat_add(s2_p1_q, s2_p2_q) : s2_d1_q;
      s3_last_q <= s2_last_q;
    end
  end

  // Stage 4: stencil term.
  logic signed [31:0] s4_a_q, s4_cp_q, s4_ks_q, s4_tmp_q;
  logic               s4_last_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_a_q    <= s3_a_q;
      s4_cp_q   <= s3_cp_q;
      s4_ks_q   <= s3_ks_q;
      s4_tmp_q  <= sfd_pkg::qmul(s3_opa_q, s3_opb_q);
      s4_last_q <= s3_last_q;
    end
  end

  // Stage 5: field update and memory-coefficient product.
  logic signed [31:0] s5_acc_q, s5_cp_q, s5_mp_q;
  logic               s5_last_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_acc_q  <= sfd_pkg::sat_add(s4_a_q, s4_tmp_q);
      s5_cp_q   <= s4_cp_q;
      s5_mp_q   <= sfd_pkg::qmul(s4_ks_q, s4_tmp_q);
      s5_last_q <= s4_last_q;
    end
  end

  // Stage 6: memory variable update into the output register.
  sfd_pkg::out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      out_q.acc_out  <= s5_acc_q;
      out_q.mem_out  <= sfd_pkg::sat_add(s5_cp_q, s5_mp_q);
      out_q.row_done <= s5_last_q;
    end
  end

  assign out_data_o = out_q;

  // Input is stalled only when every stage is full.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with an empty stage");

  // A free output never holds back the input.
  a_free_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

  // A beat that moves on lands in the next stage.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && en[1]) |=> v_q[1])
    else $error("beat lost between stages one and two");

  // While the output is held, no beat inside the pipeline is dropped.
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($countones(v_q) >= $past($countones(v_q))))
    else $error("beat dropped while output stalled");

endmodule
